// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the serial frame receiver.
// No dependencies; used by sfr_deframer and serial_frame_receiver.
package sfr_pkg;

  localparam logic [7:0] START_MARK     = 8'h7E;
  localparam logic [7:0] END_MARK       = 8'hFE;
  localparam logic [7:0] SUM_BASE       = 8'hFF;
  localparam logic [7:0] EMERGENCY_TYPE = 8'h0F;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;
  localparam logic [7:0] LIMIT_RESET    = 8'd16;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_LONG = 2'd1,
    ERR_COUNT    = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_t;

  typedef struct packed {
    logic       frame_ok;
    err_t       error_code;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic       emergency_stop;
  } report_t;

endpackage

// ===== rtl/serial_frame_receiver.sv =====
// An accepted word waits in the input register until the deframer takes it; a frame
// report is registered in the result register when its checksum word is taken.
// Throughput: one word per cycle; the input register stalls only when a
// report is due and the result register still holds an untaken report.
// Reset (rst, synchronous): returns to start hunt, empties both registers
// and sets the length limit to 16. Depends on sfr_pkg and sfr_deframer.
module serial_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_ok,
  output logic [1:0] error_code,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length,
  output logic [7:0] first_data,
  output logic [7:0] second_data,
  output logic       emergency_stop
);

  logic [7:0]       limit_reg;
  logic             byte_valid;
  logic [7:0]       byte_reg;
  logic             report_due;
  logic             advance;
  logic             slot_free;
  sfr_pkg::report_t report;
  sfr_pkg::report_t result_reg;

  assign slot_free    = !out_valid || out_ready;
  assign advance      = byte_valid && (!report_due || slot_free);
  assign in_ready     = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= sfr_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_reg <= cfg_wdata;
    end
  end

  // input register: hold the word until the deframer can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_reg <= rx_byte;
    end
  end

  sfr_deframer u_deframer (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .byte_in      (byte_reg),
    .length_limit (limit_reg),
    .report_due   (report_due),
    .report       (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && report_due) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && report_due) begin
      result_reg <= report;
    end
  end

  assign frame_ok       = result_reg.frame_ok;
  assign error_code     = result_reg.error_code;
  assign frame_type     = result_reg.frame_type;
  assign frame_length   = result_reg.frame_length;
  assign first_data     = result_reg.first_data;
  assign second_data    = result_reg.second_data;
  assign emergency_stop = result_reg.emergency_stop;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_reg)))
    else $error("pending report overwritten");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !advance) |=> (byte_valid && $stable(byte_reg)))
    else $error("stalled word lost");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_ok == (error_code == sfr_pkg::ERR_NONE)))
    else $error("status flag disagrees with error code");

endmodule

// ===== rtl/sfr_deframer.sv =====
// Frame state for the serial frame receiver: start hunt, length, type and
// data capture, running sum and the frame report. Depends on sfr_pkg.
module sfr_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic [7:0]        length_limit,
  output logic              report_due,
  output sfr_pkg::report_t  report
);

  logic       in_frame, in_frame_next;
  logic       checksum_next, checksum_next_next;
  logic       have_length, have_length_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] type_seen, type_seen_next;
  logic [7:0] data_zero, data_zero_next;
  logic [7:0] data_one, data_one_next;
  logic [7:0] running_sum, running_sum_next;

  logic [7:0] need;
  logic [7:0] expect_sum;

  assign report_due = in_frame && checksum_next;
  assign need       = (declared_length == 8'd0) ? 8'd1 : declared_length;
  assign expect_sum = sfr_pkg::SUM_BASE - running_sum;

  always_comb begin
    if (declared_length > length_limit) begin
      report.error_code = sfr_pkg::ERR_TOO_LONG;
    end else if (byte_position != need) begin
      report.error_code = sfr_pkg::ERR_COUNT;
    end else if (byte_in != expect_sum) begin
      report.error_code = sfr_pkg::ERR_CHECKSUM;
    end else begin
      report.error_code = sfr_pkg::ERR_NONE;
    end
    report.frame_ok       = (report.error_code == sfr_pkg::ERR_NONE);
    report.frame_type     = type_seen;
    report.frame_length   = declared_length;
    report.first_data     = data_zero;
    report.second_data    = data_one;
    report.emergency_stop = (type_seen == sfr_pkg::EMERGENCY_TYPE);
  end

  always_comb begin
    in_frame_next        = in_frame;
    checksum_next_next   = checksum_next;
    have_length_next     = have_length;
    byte_position_next   = byte_position;
    declared_length_next = declared_length;
    type_seen_next       = type_seen;
    data_zero_next       = data_zero;
    data_one_next        = data_one;
    running_sum_next     = running_sum;
    if (step) begin
      if (!in_frame || checksum_next) begin
        // open a fresh frame on a start mark; the checksum word closes it
        in_frame_next        = !in_frame && (byte_in == sfr_pkg::START_MARK);
        checksum_next_next   = 1'b0;
        have_length_next     = 1'b0;
        byte_position_next   = 8'd0;
        declared_length_next = 8'd0;
        type_seen_next       = 8'd0;
        data_zero_next       = 8'd0;
        data_one_next        = 8'd0;
        running_sum_next     = 8'd0;
        if (!in_frame && byte_in != sfr_pkg::START_MARK) begin
          // drop the word, keep hunting
          in_frame_next = 1'b0;
        end
      end else if (!have_length) begin
        declared_length_next = byte_in;
        have_length_next     = 1'b1;
        checksum_next_next   = (byte_in == sfr_pkg::END_MARK);
      end else if (byte_in == sfr_pkg::END_MARK) begin
        checksum_next_next = 1'b1;
      end else begin
        if (byte_position == 8'd0) begin
          type_seen_next = byte_in;
        end
        if (byte_position == 8'd1) begin
          data_zero_next = byte_in;
        end
        if (byte_position == 8'd2) begin
          data_one_next = byte_in;
        end
        if (byte_position < declared_length) begin
          running_sum_next = running_sum + byte_in;
        end
        if (byte_position != sfr_pkg::COUNT_MAX) begin
          byte_position_next = byte_position + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      checksum_next   <= 1'b0;
      have_length     <= 1'b0;
      byte_position   <= 8'd0;
      declared_length <= 8'd0;
      type_seen       <= 8'd0;
      data_zero       <= 8'd0;
      data_one        <= 8'd0;
      running_sum     <= 8'd0;
    end else begin
      in_frame        <= in_frame_next;
      checksum_next   <= checksum_next_next;
      have_length     <= have_length_next;
      byte_position   <= byte_position_next;
      declared_length <= declared_length_next;
      type_seen       <= type_seen_next;
      data_zero       <= data_zero_next;
      data_one        <= data_one_next;
      running_sum     <= running_sum_next;
    end
  end

  a_checksum_in_frame: assert property (@(posedge clk) disable iff (rst)
    checksum_next |-> (in_frame && have_length))
    else $error("checksum pending outside a frame");

  a_count_needs_length: assert property (@(posedge clk) disable iff (rst)
    (byte_position != 8'd0) |-> have_length)
    else $error("bytes counted before the length word");

  a_report_closes: assert property (@(posedge clk) disable iff (rst)
    (step && report_due) |=> !in_frame)
    else $error("frame not closed after its report");

  a_hunt_holds: assert property (@(posedge clk) disable iff (rst)
    (!in_frame && !step) |=> !in_frame)
    else $error("frame opened without a word");

endmodule

// ===== bench/sfr_checker.sv =====
`timescale 1ns / 1ps
// Frame report checker for serial_frame_receiver: tracks the deframing state of
// every accepted word and compares each report taken with the one predicted.
// Depends on sfr_pkg for the marks, the error codes and the report layout.
module sfr_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       frame_ok,
  input  logic [1:0] error_code,
  input  logic [7:0] frame_type,
  input  logic [7:0] frame_length,
  input  logic [7:0] first_data,
  input  logic [7:0] second_data,
  input  logic       emergency_stop,
  output int         errors,
  output int         pending
);

  logic [7:0]       limit_q;
  logic             in_frame;
  logic             sum_next;
  logic             len_taken;
  logic [7:0]       body_count;
  logic [7:0]       frame_len;
  logic [7:0]       type_b;
  logic [7:0]       data0;
  logic [7:0]       data1;
  logic [7:0]       body_sum;
  int               fail_count;
  sfr_pkg::report_t expected_reports [$];

  task clear_frame_state();
    in_frame   = 1'b0;
    sum_next   = 1'b0;
    len_taken  = 1'b0;
    body_count = '0;
    frame_len  = '0;
    type_b     = '0;
    data0      = '0;
    data1      = '0;
    body_sum   = '0;
  endtask

  // Advance the frame state by one word; queue a report at the checksum word.
  task take_word(input logic [7:0] b);
    sfr_pkg::report_t rep;
    logic [7:0]       need;
    logic [7:0]       want_sum;
    if (!in_frame) begin
      if (b == sfr_pkg::START_MARK) begin
        clear_frame_state();
        in_frame = 1'b1;
      end
    end else if (sum_next) begin
      need     = (frame_len == 8'd0) ? 8'd1 : frame_len;
      want_sum = sfr_pkg::SUM_BASE - body_sum;
      if (frame_len > limit_q) rep.error_code = sfr_pkg::ERR_TOO_LONG;
      else if (body_count != need) rep.error_code = sfr_pkg::ERR_COUNT;
      else if (b != want_sum) rep.error_code = sfr_pkg::ERR_CHECKSUM;
      else rep.error_code = sfr_pkg::ERR_NONE;
      rep.frame_ok       = (rep.error_code == sfr_pkg::ERR_NONE);
      rep.frame_type     = type_b;
      rep.frame_length   = frame_len;
      rep.first_data     = data0;
      rep.second_data    = data1;
      rep.emergency_stop = (type_b == sfr_pkg::EMERGENCY_TYPE);
      expected_reports.push_back(rep);
      clear_frame_state();
    end else if (!len_taken) begin
      // a length of 0xFE also closes the body at once
      frame_len = b;
      len_taken = 1'b1;
      if (b == sfr_pkg::END_MARK) sum_next = 1'b1;
    end else if (b == sfr_pkg::END_MARK) begin
      sum_next = 1'b1;
    end else begin
      case (body_count)
        8'd0: type_b = b;
        8'd1: data0 = b;
        8'd2: data1 = b;
        default: ;
      endcase
      if (body_count < frame_len) body_sum = body_sum + b;
      if (body_count != sfr_pkg::COUNT_MAX) body_count = body_count + 8'd1;
    end
  endtask

  always @(posedge clk) begin
    sfr_pkg::report_t seen;
    sfr_pkg::report_t want;
    if (rst) begin
      limit_q = sfr_pkg::LIMIT_RESET;
      clear_frame_state();
      expected_reports.delete();
      fail_count = 0;
    end else begin
      // compare before queueing, so a report with nothing waiting is caught
      if (out_valid && out_ready) begin
        seen.frame_ok       = frame_ok;
        seen.error_code     = sfr_pkg::err_t'(error_code);
        seen.frame_type     = frame_type;
        seen.frame_length   = frame_length;
        seen.first_data     = first_data;
        seen.second_data    = second_data;
        seen.emergency_stop = emergency_stop;
        if (expected_reports.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected report ok=%0d err=%0d type=%h len=%h d0=%h d1=%h em=%0d",
                     $realtime, seen.frame_ok, seen.error_code, seen.frame_type,
                     seen.frame_length, seen.first_data, seen.second_data,
                     seen.emergency_stop);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (seen.frame_ok !== want.frame_ok || seen.error_code !== want.error_code ||
              seen.frame_type !== want.frame_type ||
              seen.frame_length !== want.frame_length ||
              seen.first_data !== want.first_data ||
              seen.second_data !== want.second_data ||
              seen.emergency_stop !== want.emergency_stop) begin
            if (fail_count < 10) begin
              $display("%0t: report mismatch", $realtime);
              $display("  exp ok=%0d err=%0d type=%h len=%h d0=%h d1=%h em=%0d",
                       want.frame_ok, want.error_code, want.frame_type,
                       want.frame_length, want.first_data, want.second_data,
                       want.emergency_stop);
              $display("  got ok=%0d err=%0d type=%h len=%h d0=%h d1=%h em=%0d",
                       seen.frame_ok, seen.error_code, seen.frame_type,
                       seen.frame_length, seen.first_data, seen.second_data,
                       seen.emergency_stop);
            end
            fail_count++;
          end
        end
      end
      if (cfg_we) limit_q = cfg_wdata;
      if (in_valid && in_ready) take_word(rx_byte);
    end
    errors  <= fail_count;
    pending <= expected_reports.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for serial_frame_receiver: directed frames, a long output
// hold-off, then random frames under several length limits. Uses sfr_checker.
module tb_top;

  localparam int TOTAL_WORDS = 1450;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       frame_ok;
  logic [1:0] error_code;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic       emergency_stop;

  int         errors;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_left = 0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         sent_words = 0;
  logic [7:0] limit_now = sfr_pkg::LIMIT_RESET;

  serial_frame_receiver u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .rx_byte,
    .out_valid, .out_ready,
    .frame_ok, .error_code, .frame_type, .frame_length,
    .first_data, .second_data, .emergency_stop
  );

  sfr_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .rx_byte,
    .out_valid, .out_ready,
    .frame_ok, .error_code, .frame_type, .frame_length,
    .first_data, .second_data, .emergency_stop,
    .errors, .pending
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
      if (!hold_req) hold_done <= 1'b0;
    end
  end

  task automatic send_word(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
  endtask

  // Drop valid and hold until every report has been taken and the pipe is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = v;
  endtask

  // Start, length, body, end mark, checksum; a length of 0xFE goes straight to the checksum.
  task automatic send_frame(input logic [7:0] len, input int nbody, input bit bad_sum);
    logic [7:0] body [$];
    logic [7:0] acc;
    logic [7:0] b;
    logic [7:0] csum;
    acc = '0;
    for (int i = 0; i < nbody; i++) begin
      do b = 8'($urandom_range(255)); while (b == sfr_pkg::END_MARK);
      if (i == 0 && $urandom_range(9) == 0) b = sfr_pkg::EMERGENCY_TYPE;
      body.push_back(b);
      if (i < int'(len)) acc = acc + b;
    end
    csum = sfr_pkg::SUM_BASE - acc;
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    send_word(sfr_pkg::START_MARK);
    send_word(len);
    if (len != sfr_pkg::END_MARK) begin
      foreach (body[i]) send_word(body[i]);
      send_word(sfr_pkg::END_MARK);
    end
    send_word(len == sfr_pkg::END_MARK ? 8'($urandom_range(255)) : csum);
  endtask

  task automatic random_frame();
    int         kind;
    int         n;
    int         d;
    logic [7:0] len;
    logic [7:0] need;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // line noise, may open a frame that the next one runs into
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(255)));
    end else if (kind < 12) begin
      send_frame(sfr_pkg::END_MARK, 0, 1'b0);
    end else if (kind < 20) begin
      send_frame(8'($urandom_range(255)), $urandom_range(0, 6), 1'($urandom_range(1)));
    end else if (kind < 30) begin
      len  = 8'($urandom_range(0, 12));
      need = (len == 8'd0) ? 8'd1 : len;
      d    = $urandom_range(1, 2);
      n    = $urandom_range(1) ? int'(need) + d : int'(need) - d;
      if (n < 0) n = 0;
      send_frame(len, n, 1'($urandom_range(1)));
    end else if (kind < 31) begin
      send_frame(8'($urandom_range(200, 255)), $urandom_range(200, 300), 1'b0);
    end else begin
      len = 8'($urandom_range(0, 12));
      if ($urandom_range(7) == 0) len = limit_now;
      if (len == sfr_pkg::END_MARK) len = 8'd0;
      need = (len == 8'd0) ? 8'd1 : len;
      send_frame(len, int'(need), $urandom_range(4) == 0);
    end
  endtask

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under the reset limit
    send_word(8'h00);
    send_word(8'hFF);
    // zero length still needs its type word; emergency type
    send_word(sfr_pkg::START_MARK); send_word(8'h00); send_word(sfr_pkg::EMERGENCY_TYPE);
    send_word(sfr_pkg::END_MARK);   send_word(sfr_pkg::SUM_BASE);
    // length word doubles as the end mark
    send_word(sfr_pkg::START_MARK); send_word(sfr_pkg::END_MARK); send_word(8'h5A);
    // start mark inside a frame is data; checksum off by one
    send_word(sfr_pkg::START_MARK); send_word(8'h02); send_word(sfr_pkg::START_MARK);
    send_word(8'h55);      send_word(sfr_pkg::END_MARK); send_word(8'h2D);
    // one over the limit
    send_word(sfr_pkg::START_MARK); send_word(sfr_pkg::LIMIT_RESET + 8'd1);
    send_word(8'h01);
    send_word(sfr_pkg::END_MARK);   send_word(8'h00);
    // data words missing
    send_word(sfr_pkg::START_MARK); send_word(8'h03); send_word(8'h01); send_word(8'h02);
    send_word(sfr_pkg::END_MARK);   send_word(8'hFC);
    drain();

    // hold the output off while short frames keep coming, so the input stalls
    hold_req <= 1'b1;
    repeat (12) send_frame(8'($urandom_range(0, 2)), 3, 1'b0);
    hold_req <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle_pct = 25; rx_stall_pct <= 63; end
        1: begin tx_idle_pct = 63; rx_stall_pct <= 25; end
        default: begin tx_idle_pct = 0; rx_stall_pct <= 0; end
      endcase
      case (ph)
        0, 4: write_limit(8'hFF);
        1: write_limit(8'h00);
        2: write_limit(8'($urandom_range(1, 254)));
        3: write_limit(8'd8);
        default: write_limit(sfr_pkg::LIMIT_RESET);
      endcase
      // length 255: 300 body words saturate the count and still pass; 255 words pass too
      if (ph == 0) send_frame(8'hFF, 300, 1'b0);
      if (ph == 4) send_frame(8'hFF, 255, 1'b0);
      while (sent_words < (ph + 1) * TOTAL_WORDS / 6) random_frame();
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfr_pkg.sv
rtl/sfr_deframer.sv
rtl/serial_frame_receiver.sv
bench/sfr_checker.sv
bench/tb_top.sv
